// ===== rtl/fprc_pkg.sv =====
package fprc_pkg;

  // Frame delimiters and special values
  localparam logic [7:0] START_BYTE = 8'h49;
  localparam logic [7:0] END_BYTE   = 8'h4D;
  localparam logic [7:0] BROADCAST  = 8'hFF;

  // Command codes
  localparam logic [7:0] CMD_SLEEP      = 8'h02;
  localparam logic [7:0] CMD_WAKE       = 8'h03;
  localparam logic [7:0] CMD_DATA       = 8'h11;
  localparam logic [7:0] CMD_PARAMS     = 8'h12;
  localparam logic [7:0] CMD_REPORT_OFF = 8'h18;
  localparam logic [7:0] CMD_REPORT_ON  = 8'h19;

  // Euler tag 0x0040 is bit 6 of the little-endian word at payload byte 1
  localparam int         TAG_POS       = 1;
  localparam int         TAG_BIT       = 6;
  localparam int         EULER_FIRST   = 7;
  localparam int         EULER_BYTES   = 6;
  localparam int         IDX_W         = 7;
  localparam logic [6:0] EULER_MIN_LEN = 7'd13;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BROADCAST,
    ERR_LENGTH,
    ERR_CHECKSUM,
    ERR_END,
    ERR_ADDRESS
  } frame_err_t;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_SLEEP_ACK,
    KIND_WAKE_ACK,
    KIND_DATA_REPORT,
    KIND_PARAMS_ACK,
    KIND_REPORT_OFF,
    KIND_REPORT_ON
  } reply_kind_t;

  typedef struct packed {
    logic               done;
    frame_err_t         err;
    logic [7:0]         cmd;
    reply_kind_t        kind;
    logic               upd;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } rx_result_t;

  function automatic reply_kind_t kind_of(logic [7:0] code);
    reply_kind_t k;
    unique case (code)
      CMD_SLEEP:      k = KIND_SLEEP_ACK;
      CMD_WAKE:       k = KIND_WAKE_ACK;
      CMD_DATA:       k = KIND_DATA_REPORT;
      CMD_PARAMS:     k = KIND_PARAMS_ACK;
      CMD_REPORT_OFF: k = KIND_REPORT_OFF;
      CMD_REPORT_ON:  k = KIND_REPORT_ON;
      default:        k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/fprc_deframer.sv =====
module fprc_deframer import fprc_pkg::*; #(
  parameter int MAX_PAYLOAD = 73
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output rx_result_t result
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN,
    PH_PAYLOAD,
    PH_CSUM,
    PH_TAIL
  } phase_t;

  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   byte_index, byte_index_next, idx_inc;
  logic [7:0]         running_sum, running_sum_next;
  logic [7:0]         frame_address, frame_address_next;
  logic [IDX_W-1:0]   frame_length, frame_length_next;
  logic [7:0]         device_address;
  logic [7:0]         cmd_byte;
  logic               tag_set;
  logic [7:0]         euler_byte [EULER_BYTES];
  logic signed [15:0] held_x, held_y, held_z;
  logic signed [15:0] new_x, new_y, new_z;

  assign idx_inc = byte_index + IDX_W'(1);
  assign new_x   = {euler_byte[1], euler_byte[0]};
  assign new_y   = {euler_byte[3], euler_byte[2]};
  assign new_z   = {euler_byte[5], euler_byte[4]};

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    byte_index_next    = byte_index;
    frame_address_next = frame_address;
    frame_length_next  = frame_length;
    result.done        = 1'b0;
    result.err         = ERR_NONE;
    result.cmd         = '0;
    result.kind        = KIND_OTHER;
    result.upd         = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          running_sum_next = '0;
          byte_index_next  = '0;
          phase_next       = PH_ADDR;
        end
      end
      PH_ADDR: begin
        frame_address_next = rx_byte;
        running_sum_next   = running_sum + rx_byte;
        if (rx_byte == BROADCAST) begin
          result.err = ERR_BROADCAST;
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        running_sum_next = running_sum + rx_byte;
        if (rx_byte == 8'd0 || rx_byte > MaxLen) begin
          result.err = ERR_LENGTH;
          phase_next = PH_HUNT;
        end else begin
          frame_length_next = rx_byte[IDX_W-1:0];
          byte_index_next   = '0;
          phase_next        = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + rx_byte;
        byte_index_next  = idx_inc;
        if (idx_inc >= frame_length) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (running_sum == rx_byte) begin
          phase_next = PH_TAIL;
        end else begin
          result.err = ERR_CHECKSUM;
          phase_next = PH_HUNT;
        end
      end
      PH_TAIL: begin
        phase_next = PH_HUNT;
        if (rx_byte != END_BYTE) begin
          result.err = ERR_END;
        end else if (device_address != BROADCAST && device_address != frame_address) begin
          result.err = ERR_ADDRESS;
        end else begin
          result.done = 1'b1;
          result.cmd  = cmd_byte;
          result.kind = kind_of(cmd_byte);
          result.upd  = (cmd_byte == CMD_DATA) && (frame_length >= EULER_MIN_LEN)
                        && ({1'b0, frame_length} <= MaxLen) && tag_set;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
    result.ax = result.upd ? new_x : held_x;
    result.ay = result.upd ? new_y : held_y;
    result.az = result.upd ? new_z : held_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      running_sum    <= '0;
      byte_index     <= '0;
      frame_address  <= '0;
      frame_length   <= '0;
      device_address <= BROADCAST;
      held_x         <= '0;
      held_y         <= '0;
      held_z         <= '0;
    end else begin
      if (cfg_write) begin
        device_address <= cfg_data;
      end
      if (step) begin
        phase         <= phase_next;
        running_sum   <= running_sum_next;
        byte_index    <= byte_index_next;
        frame_address <= frame_address_next;
        frame_length  <= frame_length_next;
        held_x        <= result.ax;
        held_y        <= result.ay;
        held_z        <= result.az;
      end
    end
  end

  // Keep only the payload bytes that are ever read: command, tag and angles
  always_ff @(posedge clk) begin
    if (step && phase == PH_PAYLOAD) begin
      if (byte_index == '0) begin
        cmd_byte <= rx_byte;
      end
      if (byte_index == IDX_W'(TAG_POS)) begin
        tag_set <= rx_byte[TAG_BIT];
      end
      for (int k = 0; k < EULER_BYTES; k++) begin
        if (byte_index == IDX_W'(EULER_FIRST + k)) begin
          euler_byte[k] <= rx_byte;
        end
      end
    end
  end

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    result.done |-> result.err == ERR_NONE)
    else $error("completed packet carries an error code");

  a_upd_data: assert property (@(posedge clk) disable iff (rst)
    result.upd |-> result.done && result.cmd == CMD_DATA)
    else $error("angle update without a completed data report");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_index < frame_length)
    else $error("payload index ran past frame length");

  a_tail_hunt: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_TAIL |=> phase == PH_HUNT)
    else $error("deframer did not return to hunting after end byte");

endmodule

// ===== rtl/framed_packet_receiver_checksum_core.sv =====
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  rx_byte
// out       out  out_valid/ out_stall packet_done, frame_error, command_code,
//                                     reply_kind, angles_updated, angle_x/y/z
// cfg       in   cfg_write            cfg_data (device_address)
//
// One result per received byte; one byte per cycle sustained while out_stall is low.
// The deframer state is updated in the cycle of the input transfer; the result
// lands in a two-entry output buffer (output register plus skid register).
// in_stall is the skid register's valid bit, so input is held only when both
// entries are full.
// Synchronous active-high rst: hunting for a start byte, device_address 255,
// held angles zero, output buffer empty.
module framed_packet_receiver_checksum_core import fprc_pkg::*; #(
  parameter int MAX_PAYLOAD = 73
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               packet_done,
  output logic [2:0]         frame_error,
  output logic [7:0]         command_code,
  output logic [2:0]         reply_kind,
  output logic               angles_updated,
  output logic signed [15:0] angle_x,
  output logic signed [15:0] angle_y,
  output logic signed [15:0] angle_z
);

  rx_result_t step_result;
  rx_result_t out_q;
  rx_result_t skid_q;
  logic       skid_valid;
  logic       in_xfer;
  logic       out_xfer;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !skid_valid;
  assign out_xfer = out_valid && !out_stall;

  fprc_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .step     (in_xfer),
    .rx_byte  (rx_byte),
    .result   (step_result)
  );

  // Output buffer: fill the output register when it is free or draining,
  // otherwise park the new result in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      if (!out_valid || !out_stall) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      // Advance the skid entry, or empty the buffer
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!out_valid || !out_stall) begin
        out_q <= step_result;
      end else begin
        skid_q <= step_result;
      end
    end else if (out_xfer && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign packet_done    = out_q.done;
  assign frame_error    = out_q.err;
  assign command_code   = out_q.cmd;
  assign reply_kind     = out_q.kind;
  assign angles_updated = out_q.upd;
  assign angle_x        = out_q.ax;
  assign angle_y        = out_q.ay;
  assign angle_z        = out_q.az;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_xfer && out_valid && out_stall |=> skid_valid)
    else $error("result lost while output was stalled");

  a_drain_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid && out_valid)
    else $error("skid entry not advanced on output transfer");

endmodule
